### rtl/tgcw_pkg.sv
// shared types, constants and helpers for the text grid console writer
// no dependencies

package tgcw_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

  localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COLS_W  = $clog2(MAX_COLS + 1);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [20:0] NEWLINE_CODE = 21'd10;
  localparam logic [20:0] SPACE_CODE   = 21'd32;
  localparam logic [14:0] POS_LIMIT    = 15'h7fff;
  localparam logic [15:0] ROW_SAT      = 16'h8000;

  typedef enum logic [2:0] {
    FN_PUT   = 3'd0,
    FN_MOVE  = 3'd1,
    FN_CLEAR = 3'd2,
    FN_READ  = 3'd3,
    FN_ACK   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_WRITTEN  = 2'd0,
    ST_NEWLINE  = 2'd1,
    ST_OFF_GRID = 2'd2,
    ST_DONE     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 1'd0,
    CFG_ROWS = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [20:0] ch;
    logic [3:0]  sty;
    logic [31:0] lnk;
  } cell_t;

  localparam cell_t BLANK_CELL = '{ch: SPACE_CODE, sty: 4'd0, lnk: 32'd0};

  typedef struct packed {
    logic               we;
    logic               re;
    logic [CELL_AW-1:0] addr;
    cell_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic              set_row;
    logic [ROW_AW-1:0] row;
    logic              mark_vis;
    logic              ack_vis;
  } dirty_cmd_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_AW-1:0] row,
                                                   input logic [COL_AW-1:0] col);
    logic [CELL_AW-1:0] a;
    a = CELL_AW'(row) * CELL_AW'(MAX_COLS) + CELL_AW'(col);
    return a;
  endfunction

  function automatic logic [15:0] row_inc(input logic [15:0] r);
    return (r < ROW_SAT) ? r + 16'd1 : r;
  endfunction

endpackage

### rtl/text_grid_console_writer.sv
// top level of the text grid console writer: command decode, cursor, sweep control
// depends on tgcw_pkg, tgcw_cell_mem and tgcw_dirty_flags

// Usage
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low; func_i selects put_char, move_cursor, clear, read_cell or ack_update.
//   Result channel: done_o is high for exactly one cycle per transaction and the
//   result ports are valid in that cycle; the receiver cannot stall it.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 grid_cols, 1 grid_rows) at the edge; write only while nothing is pending.
// Result timing and throughput
//   put_char, move_cursor, read_cell, ack_update and unknown codes: result in the
//   cycle after acceptance, one transaction per cycle. read_cell takes its data
//   from the registered read port of the cell memory.
//   clear: busy while the visible area is blanked, one cell per cycle through the
//   single memory port; result in the cycle after the last write.
// Reset
//   after reset busy stays high while every cell of the memory (MAX_COLS*MAX_ROWS,
//   8192 cells) is written to a space; cursor, flags and sizes reset at once.

module text_grid_console_writer
  import tgcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func_i,
  input  logic [20:0]          char_code_i,
  input  logic [3:0]           cell_style_i,
  input  logic [31:0]          link_value_i,
  input  logic [15:0]          pos_x_i,
  input  logic [15:0]          pos_y_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [20:0]          out_char_o,
  output logic [3:0]           out_style_o,
  output logic [31:0]          out_link_o,
  output logic                 row_dirty_o,
  output logic [14:0]          cursor_x_o,
  output logic [15:0]          cursor_y_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_INIT  = 3'b010,
    S_CLEAR = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [7:0]        grid_cols_q;
  logic [6:0]        grid_rows_q;
  logic [14:0]       cur_col_q, cur_col_d;
  logic [15:0]       cur_row_q, cur_row_d;
  logic [COL_AW-1:0] sw_col_q, sw_col_d;
  logic [ROW_AW-1:0] sw_row_q, sw_row_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic              read_hit_q, read_hit_d;
  logic              row_dirty_q, row_dirty_d;

  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;
  logic [COLS_W-1:0] lim_col;
  logic [ROWS_W-1:0] lim_row;
  logic              col_last, row_last;
  logic              accept;
  logic              wrap, off_grid, read_in;
  logic [14:0]       col1;
  logic [15:0]       row1;
  mem_req_t          mem_req;
  cell_t             rdata;
  dirty_cmd_t        dcmd;
  logic              row_flag, all_dirty;

  // sizes in use, capped at the array limits
  assign cols = (16'(grid_cols_q) > 16'(MAX_COLS)) ? COLS_W'(MAX_COLS) : COLS_W'(grid_cols_q);
  assign rows = (16'(grid_rows_q) > 16'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : ROWS_W'(grid_rows_q);

  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= '0;
      grid_rows_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLS: grid_cols_q <= cfg_wdata_i;
        CFG_ROWS: grid_rows_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // sweep limits: whole memory during init, visible area during clear
  assign lim_col  = (state_q == S_INIT) ? COLS_W'(MAX_COLS - 1) : cols - COLS_W'(1);
  assign lim_row  = (state_q == S_INIT) ? ROWS_W'(MAX_ROWS - 1) : rows - ROWS_W'(1);
  assign col_last = (COLS_W'(sw_col_q) == lim_col);
  assign row_last = (ROWS_W'(sw_row_q) == lim_row);

  // put_char wrap and edge checks
  assign wrap     = (16'(cur_col_q) >= 16'(cols));
  assign col1     = wrap ? 15'd0 : cur_col_q;
  assign row1     = wrap ? row_inc(cur_row_q) : cur_row_q;
  assign off_grid = (row1 >= 16'(rows));
  assign read_in  = (pos_x_i < 16'(cols)) && (pos_y_i < 16'(rows));

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    sw_col_d    = sw_col_q;
    sw_row_d    = sw_row_q;
    done_d      = 1'b0;
    status_d    = status_q;
    read_hit_d  = read_hit_q;
    row_dirty_d = row_dirty_q;
    mem_req     = '{we: 1'b0, re: 1'b0, addr: cell_addr(sw_row_q, sw_col_q),
                    wdata: BLANK_CELL};
    dcmd        = '{set_row: 1'b0, row: row1[ROW_AW-1:0], mark_vis: 1'b0, ack_vis: 1'b0};

    case (state_q)
      S_INIT, S_CLEAR: begin
        mem_req.we = 1'b1;
        if (col_last) begin
          sw_col_d = '0;
          sw_row_d = sw_row_q + ROW_AW'(1);
        end else begin
          sw_col_d = sw_col_q + COL_AW'(1);
        end
        if (col_last && row_last) begin
          sw_row_d = '0;
          state_d  = S_IDLE;
          done_d   = (state_q == S_CLEAR);
        end
      end
      S_IDLE: begin
        if (accept) begin
          done_d      = 1'b1;
          status_d    = ST_DONE;
          read_hit_d  = 1'b0;
          row_dirty_d = 1'b0;
          case (func_i)
            FN_PUT: begin
              cur_col_d = col1;
              cur_row_d = row1;
              if (off_grid) begin
                status_d = ST_OFF_GRID;
              end else if (char_code_i == NEWLINE_CODE) begin
                cur_col_d = 15'd0;
                cur_row_d = row_inc(row1);
                status_d  = ST_NEWLINE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.addr  = cell_addr(row1[ROW_AW-1:0], col1[COL_AW-1:0]);
                mem_req.wdata = '{ch: char_code_i, sty: cell_style_i, lnk: link_value_i};
                dcmd.set_row  = 1'b1;
                cur_col_d     = col1 + 15'd1;
                status_d      = ST_WRITTEN;
              end
            end
            FN_MOVE: begin
              cur_col_d = pos_x_i[15] ? POS_LIMIT : pos_x_i[14:0];
              cur_row_d = pos_y_i[15] ? 16'(POS_LIMIT) : pos_y_i;
            end
            FN_CLEAR: begin
              cur_col_d     = 15'd0;
              cur_row_d     = 16'd0;
              dcmd.mark_vis = 1'b1;
              if ((cols != '0) && (rows != '0)) begin
                done_d  = 1'b0;
                state_d = S_CLEAR;
              end
            end
            FN_READ: begin
              mem_req.re   = 1'b1;
              mem_req.addr = cell_addr(pos_y_i[ROW_AW-1:0], pos_x_i[COL_AW-1:0]);
              read_hit_d   = read_in;
              row_dirty_d  = read_in ? (row_flag | all_dirty) : all_dirty;
            end
            FN_ACK: begin
              dcmd.ack_vis = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cur_col_q <= '0;
      cur_row_q <= '0;
      sw_col_q  <= '0;
      sw_row_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      sw_col_q  <= sw_col_d;
      sw_row_q  <= sw_row_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    read_hit_q  <= read_hit_d;
    row_dirty_q <= row_dirty_d;
  end

  tgcw_cell_mem u_cell_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  tgcw_dirty_flags u_dirty_flags (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dcmd),
    .rows_i      (rows),
    .rd_row_i    (pos_y_i[ROW_AW-1:0]),
    .row_flag_o  (row_flag),
    .all_dirty_o (all_dirty)
  );

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_char_o  = read_hit_q ? rdata.ch : 21'd0;
  assign out_style_o = read_hit_q ? rdata.sty : 4'd0;
  assign out_link_o  = read_hit_q ? rdata.lnk : 32'd0;
  assign row_dirty_o = row_dirty_q;
  assign cursor_x_o  = cur_col_q;
  assign cursor_y_o  = cur_row_q;

endmodule

### rtl/tgcw_cell_mem.sv
// cell store: one synchronous memory, one write or one read per cycle
// depends on tgcw_pkg

module tgcw_cell_mem
  import tgcw_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output cell_t    rdata_o
);

  cell_t mem_q [CELL_COUNT];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tgcw_dirty_flags.sv
// per-row dirty flags and the whole-grid dirty flag
// depends on tgcw_pkg

module tgcw_dirty_flags
  import tgcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dirty_cmd_t        cmd_i,
  input  logic [ROWS_W-1:0] rows_i,
  input  logic [ROW_AW-1:0] rd_row_i,
  output logic              row_flag_o,
  output logic              all_dirty_o
);

  logic [MAX_ROWS-1:0] flags_q, flags_d;
  logic                all_q, all_d;

  always_comb begin
    flags_d = flags_q;
    all_d   = all_q;
    for (int r = 0; r < MAX_ROWS; r++) begin
      if (ROWS_W'(r) < rows_i) begin
        if (cmd_i.mark_vis) begin
          flags_d[r] = 1'b1;
        end
        if (cmd_i.ack_vis) begin
          flags_d[r] = 1'b0;
        end
      end
    end
    if (cmd_i.set_row) begin
      flags_d[cmd_i.row] = 1'b1;
    end
    if (cmd_i.mark_vis) begin
      all_d = 1'b1;
    end
    if (cmd_i.ack_vis) begin
      all_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '1;
      all_q   <= 1'b1;
    end else begin
      flags_q <= flags_d;
      all_q   <= all_d;
    end
  end

  assign row_flag_o  = flags_q[rd_row_i];
  assign all_dirty_o = all_q;

endmodule
